/* design/nq_pkg.sv */
// Shared constants and types for the fixed-queen N-queens solver.
`timescale 1ns / 1ps
package nq_pkg;

   localparam int MAX_QUEENS = 8;
   localparam int COL_W      = 3;
   localparam int BOARD_W    = 4;
   localparam int PLACE_W    = COL_W * MAX_QUEENS;

   typedef logic [COL_W-1:0]      col_type;
   typedef logic [BOARD_W-1:0]    board_type;
   typedef logic [MAX_QUEENS-1:0] mask_type;

   // Attack masks handed from one row cell to the next
   typedef struct packed {
      mask_type cols;
      mask_type diag_up;
      mask_type diag_dn;
   } chain_type;

   // Controller to cell
   typedef struct packed {
      logic clear;
      logic try_en;
   } cell_cmd_type;

   // Cell to controller
   typedef struct packed {
      logic hit;
   } cell_stat_type;

endpackage

/* design/n_queens_fixed_queen_solver.sv */
// Top level: row-cell chain and backtracking controller of the N-queens solver.
//
//   channel   ports                                   handshake
//   request   req_fixed_row, req_fixed_col           start & !busy
//   response  rsp_found, rsp_range_error,            rsp_valid, one cycle, no stall
//             rsp_placement
//   config    csr_wdata                               csr_we
//
// A range error is reported in the cycle after start; busy stays low.
// Otherwise the search makes one try per column step or backtrack at a row, plus a
// settling state after each downward move, as the masks ripple one cell per cycle.
// Synchronous reset sets the board size to eight and idles the controller.
// The response is presented for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
module n_queens_fixed_queen_solver (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  nq_pkg::col_type              req_fixed_row,
   input  nq_pkg::col_type              req_fixed_col,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic                         rsp_range_error,
   output logic [nq_pkg::PLACE_W-1:0]   rsp_placement,
   input  logic                         csr_we,
   input  nq_pkg::board_type            csr_wdata
);
   import nq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TRY  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   board_type board_ff;
   board_type n_ff, n_in;
   logic [1:0] state_ff, state_in;
   board_type ptr_ff, ptr_in;
   logic      fwd_ff, fwd_in;
   col_type   frow_ff, frow_in;
   col_type   fcol_ff, fcol_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_range_error_ff, rsp_range_error_in;
   logic [PLACE_W-1:0] rsp_placement_ff, rsp_placement_in;

   board_type     n_eff;
   logic          accept;
   logic          range_err;
   mask_type      board_mask;
   col_type       cur_row;
   logic          cur_fixed;
   logic          cur_hit;
   logic [PLACE_W-1:0] packed_cols;

   chain_type     chain [MAX_QUEENS+1];
   cell_cmd_type  cmd   [MAX_QUEENS];
   cell_stat_type stat  [MAX_QUEENS];
   col_type       cols  [MAX_QUEENS];

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         board_ff <= board_type'(MAX_QUEENS);
      end else if (csr_we) begin
         board_ff <= csr_wdata;
      end
   end

   // Effective board size and range check of the incoming transaction
   always_comb begin
      n_eff     = (board_ff > board_type'(MAX_QUEENS)) ? board_type'(MAX_QUEENS) : board_ff;
      range_err = ({1'b0, req_fixed_row} >= n_eff) || ({1'b0, req_fixed_col} >= n_eff);
   end

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign cur_row = ptr_ff[COL_W-1:0];
   assign cur_fixed = (cur_row == frow_ff);
   assign cur_hit   = stat[cur_row].hit;

   always_comb begin
      for (int i = 0; i < MAX_QUEENS; i++) begin
         board_mask[i] = (board_type'(i) < n_ff);
      end
   end

   // Row cell chain
   assign chain[0] = '0;
   for (genvar g = 0; g < MAX_QUEENS; g++) begin : g_row
      always_comb begin
         cmd[g].clear  = accept;
         cmd[g].try_en = (state_ff == ST_TRY) && (ptr_ff < n_ff) && !cur_fixed &&
                         (cur_row == col_type'(g));
      end

      nq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .row_idx    (col_type'(g)),
         .fixed_row  (frow_ff),
         .fixed_col  (fcol_ff),
         .board_mask (board_mask),
         .cmd        (cmd[g]),
         .chain_in   (chain[g]),
         .chain_out  (chain[g+1]),
         .stat       (stat[g]),
         .col_out    (cols[g])
      );
   end

   // Pack one column per row, the fixed row from its own register
   always_comb begin
      packed_cols = '0;
      for (int i = 0; i < MAX_QUEENS; i++) begin
         packed_cols[COL_W*i +: COL_W] = (col_type'(i) == frow_ff) ? fcol_ff : cols[i];
      end
   end

   // Search controller: try at the current row, move down on a hit, back up on a miss
   always_comb begin
      state_in           = state_ff;
      ptr_in             = ptr_ff;
      fwd_in             = fwd_ff;
      n_in               = n_ff;
      frow_in            = frow_ff;
      fcol_in            = fcol_ff;
      rsp_valid_in       = 1'b0;
      rsp_found_in       = rsp_found_ff;
      rsp_range_error_in = rsp_range_error_ff;
      rsp_placement_in   = rsp_placement_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in    = n_eff;
               frow_in = req_fixed_row;
               fcol_in = req_fixed_col;
               ptr_in  = '0;
               fwd_in  = 1'b1;
               if (range_err) begin
                  rsp_valid_in       = 1'b1;
                  rsp_found_in       = 1'b0;
                  rsp_range_error_in = 1'b1;
                  rsp_placement_in   = '0;
               end else begin
                  state_in = ST_TRY;
               end
            end
         end
         ST_TRY: begin
            if (ptr_ff == n_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_found_in       = 1'b1;
               rsp_range_error_in = 1'b0;
               rsp_placement_in   = packed_cols;
               state_in           = ST_IDLE;
            end else if ((cur_fixed && fwd_ff) || (!cur_fixed && cur_hit)) begin
               ptr_in   = ptr_ff + board_type'(1);
               fwd_in   = 1'b1;
               state_in = ST_WAIT;
            end else begin
               fwd_in = 1'b0;
               if (ptr_ff == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_found_in       = 1'b0;
                  rsp_range_error_in = 1'b0;
                  rsp_placement_in   = '0;
                  state_in           = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff - board_type'(1);
               end
            end
         end
         ST_WAIT: begin
            state_in = ST_TRY;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff             <= ptr_in;
      fwd_ff             <= fwd_in;
      n_ff               <= n_in;
      frow_ff            <= frow_in;
      fcol_ff            <= fcol_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_range_error_ff <= rsp_range_error_in;
      rsp_placement_ff   <= rsp_placement_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_range_error = rsp_range_error_ff;
   assign rsp_placement   = rsp_placement_ff;

endmodule

/* design/nq_cell.sv */
// One row of the board: holds the row's queen and passes attack masks downwards.
`timescale 1ns / 1ps
module nq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  nq_pkg::col_type       row_idx,
   input  nq_pkg::col_type       fixed_row,
   input  nq_pkg::col_type       fixed_col,
   input  nq_pkg::mask_type      board_mask,
   input  nq_pkg::cell_cmd_type  cmd,
   input  nq_pkg::chain_type     chain_in,
   output nq_pkg::chain_type     chain_out,
   output nq_pkg::cell_stat_type stat,
   output nq_pkg::col_type       col_out
);
   import nq_pkg::*;

   logic      placed_ff, placed_in;
   col_type   col_ff, col_in;
   chain_type chain_ff, chain_in_next;

   mask_type own;
   col_type  row_gap;
   mask_type fix_bit;
   mask_type fixed_att;
   mask_type blocked;
   mask_type start_mask;
   mask_type cand;
   col_type  pick;

   // Own queen as a one-hot column mask
   assign own = placed_ff ? (mask_type'(1) << col_ff) : '0;

   // Squares of this row attacked by the fixed queen
   always_comb begin
      row_gap   = (row_idx > fixed_row) ? (row_idx - fixed_row) : (fixed_row - row_idx);
      fix_bit   = mask_type'(1) << fixed_col;
      fixed_att = fix_bit | (fix_bit << row_gap) | (fix_bit >> row_gap);
   end

   // Free columns from the next untried one upwards
   always_comb begin
      blocked    = chain_in.cols | chain_in.diag_up | chain_in.diag_dn | fixed_att | ~board_mask;
      start_mask = placed_ff ? ~((mask_type'(2) << col_ff) - mask_type'(1)) : '1;
      cand       = ~blocked & start_mask;
      pick       = '0;
      for (int i = MAX_QUEENS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            pick = col_type'(i);
         end
      end
   end

   assign stat.hit = |cand;
   assign col_out  = col_ff;

   // Place, advance to the next free column, or drop the queen
   always_comb begin
      placed_in = placed_ff;
      col_in    = col_ff;
      if (cmd.clear) begin
         placed_in = 1'b0;
         col_in    = '0;
      end else if (cmd.try_en) begin
         placed_in = stat.hit;
         col_in    = stat.hit ? pick : '0;
      end
   end

   // Hand masks on to the row below, diagonals shifted by one column
   always_comb begin
      if (cmd.clear) begin
         chain_in_next = '0;
      end else begin
         chain_in_next.cols    = chain_in.cols | own;
         chain_in_next.diag_up = (chain_in.diag_up | own) << 1;
         chain_in_next.diag_dn = (chain_in.diag_dn | own) >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         placed_ff <= 1'b0;
         chain_ff  <= '0;
      end else begin
         placed_ff <= placed_in;
         chain_ff  <= chain_in_next;
      end
      col_ff <= col_in;
   end

   assign chain_out = chain_ff;

endmodule
